>>> hdl/lcpp_pkg.sv
// Package for the lidar cabin packet parser: parse phase type, sync nibbles,
// cabin length and result field layout. No dependencies.
package lcpp_pkg;

    // Parse phases; unused codes fall back to hunting the first sync byte.
    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_ANGLO = 3'd2,
        PH_ANGHI = 3'd3,
        PH_CABIN = 3'd4
    } t_phase;

    localparam logic [3:0] SYNC1_NIBBLE = 4'hA;
    localparam logic [3:0] SYNC2_NIBBLE = 4'h5;

    // Byte position of the last byte of a five-byte cabin.
    localparam logic [2:0] CABIN_LAST_POS = 3'd4;

    localparam int TDATA_W = 64;
    localparam int TUSER_W = 2;

    // Result tdata layout, lowest bit first.
    localparam int IDX_LSB   = 0;
    localparam int DISTA_LSB = 4;
    localparam int DISTB_LSB = 18;
    localparam int COMPA_LSB = 32;
    localparam int COMPB_LSB = 38;
    localparam int ANGLE_LSB = 44;
    localparam int PAD_LSB   = 59;

    // Result tuser layout.
    localparam int USER_SCAN = 0;
    localparam int USER_CSUM = 1;

endpackage

>>> hdl/lidar_cabin_packet_parser.sv
// Lidar cabin packet parser: byte stream in, one decoded cabin per request out.
// Depends on lcpp_pkg.
//
// The parser takes one received byte per request on the slave stream and
// decodes express-scan style packets: it hunts for a sync byte whose high
// nibble is 0xA, then needs a byte whose high nibble is 0x5 (otherwise it
// drops that byte and hunts again). The two low nibbles form the expected
// checksum (first byte gives bits 3..0, second gives bits 7..4). The low and
// high angle bytes follow (bit 7 of the high byte is the new-scan flag), then
// CABINS_PER_PACKET cabins of five bytes. The fifth byte of each cabin yields
// one result request on the master stream with both distances, both angle
// compensations, the packet start angle and flags; tlast marks the last cabin,
// on which tuser bit 1 reports whether the XOR of the angle and cabin bytes
// matched the expected checksum (it is 0 on all other cabins). Every byte is
// handled in the cycle it is accepted, so the parser takes one byte per clock
// cycle. Ready drops only when the byte at the input would complete a cabin
// while the result register still holds a result that the sink has not taken.
module lidar_cabin_packet_parser
    import lcpp_pkg::*;
#(
    parameter int CABINS_PER_PACKET = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Slave stream
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,   // [7:0] rx_byte
    // Master stream
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata,   // [3:0] cabin_index, [17:4] distance_a,
                                                 // [31:18] distance_b, [37:32] angle_comp_a,
                                                 // [43:38] angle_comp_b, [58:44] start_angle,
                                                 // [63:59] zero
    output logic               o_m_axis_tlast,   // last_cabin
    output logic [TUSER_W-1:0] o_m_axis_tuser    // [0] new_scan, [1] checksum_ok
);

    localparam logic [3:0] LAST_IDX = 4'(CABINS_PER_PACKET - 1);

    // Parser state
    t_phase      r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic [3:0]  r_count, n_count;
    logic [7:0]  r_exp_sum, n_exp_sum;
    logic [7:0]  r_xor, n_xor;
    logic [14:0] r_angle, n_angle;
    logic        r_scan, n_scan;
    logic [7:0]  r_cabin [4];   // first four bytes of the current cabin

    // Result register
    logic        r_out_valid;
    logic [3:0]  r_out_idx;
    logic [13:0] r_out_dist_a, r_out_dist_b;
    logic [5:0]  r_out_comp_a, r_out_comp_b;
    logic [14:0] r_out_angle;
    logic        r_out_scan, r_out_last, r_out_ok;

    logic        s_accept;
    logic        cabin_end;   // next byte completes a cabin
    logic        emit;
    logic        is_last;
    logic [7:0]  b;

    assign b         = i_s_axis_tdata;
    assign cabin_end = (r_phase == PH_CABIN) && (r_pos == CABIN_LAST_POS);
    assign is_last   = (r_count == LAST_IDX);

    // Hold the input only when this byte would produce a result with no room for it.
    assign o_s_axis_tready = !cabin_end || !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign emit            = s_accept && cabin_end;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (s_accept) begin
            unique case (r_phase)
                PH_HUNT2: n_phase = (b[7:4] == SYNC2_NIBBLE) ? PH_ANGLO : PH_HUNT1;
                PH_ANGLO: n_phase = PH_ANGHI;
                PH_ANGHI: n_phase = PH_CABIN;
                PH_CABIN: n_phase = (cabin_end && is_last) ? PH_HUNT1 : PH_CABIN;
                default:  n_phase = (b[7:4] == SYNC1_NIBBLE) ? PH_HUNT2 : PH_HUNT1;
            endcase
        end
    end

    // Datapath next values
    always_comb begin
        n_pos     = r_pos;
        n_count   = r_count;
        n_exp_sum = r_exp_sum;
        n_xor     = r_xor;
        n_angle   = r_angle;
        n_scan    = r_scan;
        if (s_accept) begin
            unique case (r_phase)
                PH_HUNT2: begin
                    if (b[7:4] == SYNC2_NIBBLE) begin
                        n_exp_sum = {b[3:0], r_exp_sum[3:0]};
                    end
                end
                PH_ANGLO: begin
                    n_xor   = b;
                    n_angle = {r_angle[14:8], b};
                end
                PH_ANGHI: begin
                    n_xor   = r_xor ^ b;
                    n_angle = {b[6:0], r_angle[7:0]};
                    n_scan  = b[7];
                    n_count = '0;
                    n_pos   = '0;
                end
                PH_CABIN: begin
                    n_xor = r_xor ^ b;
                    if (cabin_end) begin
                        n_pos   = '0;
                        n_count = is_last ? 4'd0 : r_count + 4'd1;
                    end else begin
                        n_pos = r_pos + 3'd1;
                    end
                end
                default: begin
                    if (b[7:4] == SYNC1_NIBBLE) begin
                        n_exp_sum = {4'h0, b[3:0]};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT1;
            r_pos     <= '0;
            r_count   <= '0;
            r_exp_sum <= '0;
            r_xor     <= '0;
            r_angle   <= '0;
            r_scan    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_count   <= n_count;
            r_exp_sum <= n_exp_sum;
            r_xor     <= n_xor;
            r_angle   <= n_angle;
            r_scan    <= n_scan;
        end
    end

    // Capture cabin bytes 0..3 at their position.
    always_ff @(posedge i_clk) begin
        if (s_accept && (r_phase == PH_CABIN) && !cabin_end) begin
            r_cabin[r_pos[1:0]] <= b;
        end
    end

    // Result register: load on the fifth cabin byte, clear when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_idx    <= r_count;
            r_out_dist_a <= {r_cabin[1], r_cabin[0][7:2]};
            r_out_dist_b <= {r_cabin[3], r_cabin[2][7:2]};
            r_out_comp_a <= {r_cabin[0][1:0], b[3:0]};
            r_out_comp_b <= {r_cabin[2][1:0], b[7:4]};
            r_out_angle  <= r_angle;
            r_out_scan   <= r_scan;
            r_out_last   <= is_last;
            r_out_ok     <= is_last && ((r_xor ^ b) == r_exp_sum);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {
        {(TDATA_W - PAD_LSB){1'b0}},
        r_out_angle, r_out_comp_b, r_out_comp_a, r_out_dist_b, r_out_dist_a, r_out_idx
    };
    assign o_m_axis_tuser  = {r_out_ok, r_out_scan};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Never complete a cabin over a result that the sink has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready && s_accept) |-> !cabin_end)
        else $error("cabin completed while result register was stalled");

    // Checksum flag only on the last cabin.
    a_ok_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |-> !o_m_axis_tuser[USER_CSUM])
        else $error("checksum_ok set on a cabin that is not last");

    // The last cabin carries the last index.
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |->
            (o_m_axis_tdata[DISTA_LSB-1:IDX_LSB] == LAST_IDX))
        else $error("tlast on wrong cabin index");

    // Byte position stays within one cabin.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= CABIN_LAST_POS)
        else $error("byte position beyond cabin length");

    // A bad second sync byte sends the parser back to hunting.
    a_bad_sync2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (r_phase == PH_HUNT2) && (b[7:4] != SYNC2_NIBBLE))
            |=> (r_phase == PH_HUNT1))
        else $error("bad second sync byte did not restart the hunt");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking bench for the lidar cabin packet parser: byte stream in, decoded cabins out.
// Depends on lcpp_pkg and lidar_cabin_packet_parser; carries its own packet decoder
// to predict every cabin request.
module tb_top;
    import lcpp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CABINS       = 16;
    localparam int PAYLOAD_LEN  = 2 + 5 * CABINS;   // angle bytes plus cabin bytes
    localparam int RANDOM_CHUNK = 760;               // bytes per random phase, two phases
    localparam int HOLD_AT      = 400;               // accepted bytes before the long sink hold
    localparam int HOLD_LEN     = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;

    // One decoded cabin as the sink should see it.
    typedef struct {
        logic [3:0]  index;
        logic [13:0] dist_a;
        logic [13:0] dist_b;
        logic [5:0]  comp_a;
        logic [5:0]  comp_b;
        logic [14:0] angle;
        logic        scan;
        logic        last;
        logic        sum_ok;
    } t_cabin;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [7:0]         i_s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] o_m_axis_tdata;           // [3:0] index, [17:4] dist_a, [31:18] dist_b,
                                                  // [37:32] comp_a, [43:38] comp_b,
                                                  // [58:44] start angle, [63:59] zero
    logic               o_m_axis_tlast;           // last cabin
    logic [TUSER_W-1:0] o_m_axis_tuser;           // [0] new_scan, [1] checksum_ok

    lidar_cabin_packet_parser #(
        .CABINS_PER_PACKET(CABINS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 0;
    end

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    logic [7:0] rx_bytes_pending[$];      // bytes waiting for the driver
    t_cabin     cabins_due[$];            // decoded cabins not yet seen at the sink
    int         bytes_queued   = 0;
    int         bytes_accepted = 0;
    int         packets_queued = 0;
    int         cabins_checked = 0;
    int         sums_good_seen = 0;
    int         sums_bad_seen  = 0;
    int         errors         = 0;
    int         cycles         = 0;
    logic       byte_taken     = 1'b0;    // the slave request completed at the last rising edge

    // ------------------------------------------------------------------
    // Decoder state, mirrors the parser's packet walk
    // ------------------------------------------------------------------
    t_phase     dec_phase     = PH_HUNT1;
    logic [2:0] dec_pos       = '0;
    logic [3:0] dec_cabin     = '0;
    logic [7:0] dec_want_sum  = '0;
    logic [7:0] dec_xor       = '0;
    logic [14:0] dec_angle    = '0;
    logic        dec_scan     = 1'b0;
    logic [7:0]  dec_bytes[4];

    // Advance the decoder by one received byte; queue a cabin when one completes.
    task automatic decode_byte(input logic [7:0] b);
        t_cabin c;
        case (dec_phase)
            PH_HUNT2: begin
                // A bad second sync byte is dropped outright, even when it looks like a first one.
                if (b[7:4] == SYNC2_NIBBLE) begin
                    dec_want_sum[7:4] = b[3:0];
                    dec_phase = PH_ANGLO;
                end else begin
                    dec_phase = PH_HUNT1;
                end
            end
            PH_ANGLO: begin
                dec_xor = b;
                dec_angle[7:0] = b;
                dec_phase = PH_ANGHI;
            end
            PH_ANGHI: begin
                dec_xor ^= b;
                dec_angle[14:8] = b[6:0];
                dec_scan = b[7];
                dec_cabin = '0;
                dec_pos = '0;
                dec_phase = PH_CABIN;
            end
            PH_CABIN: begin
                dec_xor ^= b;
                if (dec_pos < CABIN_LAST_POS) begin
                    dec_bytes[dec_pos[1:0]] = b;
                    dec_pos++;
                end else begin
                    c.index  = dec_cabin;
                    c.dist_a = {dec_bytes[1], dec_bytes[0][7:2]};
                    c.dist_b = {dec_bytes[3], dec_bytes[2][7:2]};
                    c.comp_a = {dec_bytes[0][1:0], b[3:0]};
                    c.comp_b = {dec_bytes[2][1:0], b[7:4]};
                    c.angle  = dec_angle;
                    c.scan   = dec_scan;
                    c.last   = (dec_cabin == 4'(CABINS - 1));
                    // Report the checksum only on the last cabin; hold it at zero elsewhere.
                    c.sum_ok = c.last && (dec_xor == dec_want_sum);
                    cabins_due.push_back(c);
                    dec_pos = '0;
                    if (c.last) begin
                        dec_cabin = '0;
                        dec_phase = PH_HUNT1;
                    end else begin
                        dec_cabin++;
                    end
                end
            end
            default: begin
                dec_phase = PH_HUNT1;
                if (b[7:4] == SYNC1_NIBBLE) begin
                    dec_want_sum = {4'h0, b[3:0]};
                    dec_phase = PH_HUNT2;
                end
            end
        endcase
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both streams at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cabin want;
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles, %0d cabins outstanding",
                     $time, cycles, cabins_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        byte_taken <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n) begin
            // Predict first: a result never leaves in the edge its last byte arrives.
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                decode_byte(i_s_axis_tdata);
                bytes_accepted <= bytes_accepted + 1;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (cabins_due.size() == 0) begin
                    $display("%0t ns: unexpected cabin request, expected none, actual %h",
                             $time, o_m_axis_tdata);
                    errors++;
                end else begin
                    want = cabins_due.pop_front();
                    check_field("cabin_index", 32'(want.index),
                                32'(o_m_axis_tdata[IDX_LSB +: 4]));
                    check_field("distance_a", 32'(want.dist_a),
                                32'(o_m_axis_tdata[DISTA_LSB +: 14]));
                    check_field("distance_b", 32'(want.dist_b),
                                32'(o_m_axis_tdata[DISTB_LSB +: 14]));
                    check_field("angle_comp_a", 32'(want.comp_a),
                                32'(o_m_axis_tdata[COMPA_LSB +: 6]));
                    check_field("angle_comp_b", 32'(want.comp_b),
                                32'(o_m_axis_tdata[COMPB_LSB +: 6]));
                    check_field("start_angle", 32'(want.angle),
                                32'(o_m_axis_tdata[ANGLE_LSB +: 15]));
                    check_field("pad", '0, 32'(o_m_axis_tdata[TDATA_W-1:PAD_LSB]));
                    check_field("new_scan", 32'(want.scan), 32'(o_m_axis_tuser[USER_SCAN]));
                    check_field("last_cabin", 32'(want.last), 32'(o_m_axis_tlast));
                    check_field("checksum_ok", 32'(want.sum_ok),
                                32'(o_m_axis_tuser[USER_CSUM]));
                    cabins_checked++;
                    if (want.last && want.sum_ok) sums_good_seen++;
                    if (want.last && !want.sum_ok) sums_bad_seen++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Idle pattern: mostly short gaps, now and then a long one
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(12, 48);
    endfunction

    // ------------------------------------------------------------------
    // Driver: present the next byte at the falling edge
    // ------------------------------------------------------------------
    int src_gap   = 0;
    int src_burst = 0;

    always @(negedge i_clk) begin
        // Hold the request until it has been taken.
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || byte_taken) begin
            if (src_gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                src_gap--;
            end else if (rx_bytes_pending.size() > 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= rx_bytes_pending.pop_front();
                // Alternate between gapped traffic and back-to-back bursts.
                if (src_burst > 0) begin
                    src_burst--;
                end else begin
                    src_gap = pick_gap();
                    if ($urandom_range(0, 49) == 0) src_burst = $urandom_range(40, 160);
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sink: random back-pressure plus one long hold
    // ------------------------------------------------------------------
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    // Count the long hold here; start it early in the first random phase, once HOLD_AT bytes are in.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && bytes_accepted >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    int snk_gap   = 0;
    int snk_burst = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n || hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            i_m_axis_tready <= 1'b0;
            snk_gap--;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (snk_burst > 0) begin
                snk_burst--;
            end else if ($urandom_range(0, 99) < 30) begin
                snk_gap = pick_gap();
            end else if ($urandom_range(0, 99) == 0) begin
                snk_burst = $urandom_range(60, 200);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b);
        rx_bytes_pending.push_back(b);
        bytes_queued++;
    endtask

    // Queue a packet; fill < 0 means random payload. keep cuts the payload short.
    task automatic queue_packet(input bit good_sum, input int fill, input int keep);
        logic [7:0] payload[PAYLOAD_LEN];
        logic [7:0] sum;
        sum = '0;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            payload[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
            sum ^= payload[i];
        end
        if (!good_sum) sum ^= 8'($urandom_range(1, 255));
        queue_byte({SYNC1_NIBBLE, sum[3:0]});
        queue_byte({SYNC2_NIBBLE, sum[7:4]});
        for (int i = 0; i < keep; i++) queue_byte(payload[i]);
        packets_queued++;
    endtask

    // Noise leaning on the sync nibbles so the hunt states get exercised.
    task automatic queue_noise(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 2);
            if (r == 0) queue_byte({SYNC1_NIBBLE, 4'($urandom)});
            else if (r == 1) queue_byte({SYNC2_NIBBLE, 4'($urandom)});
            else queue_byte(8'($urandom));
        end
    endtask

    // Block until every byte is in and every cabin has been seen.
    task automatic wait_drained();
        while (bytes_accepted != bytes_queued || cabins_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic queue_random_phase();
        int start;
        int r;
        start = bytes_queued;
        while (bytes_queued - start < RANDOM_CHUNK) begin
            r = $urandom_range(0, 99);
            if (r < 78) begin
                queue_packet($urandom_range(0, 3) != 0, -1, PAYLOAD_LEN);
            end else if (r < 88) begin
                queue_noise($urandom_range(1, 6));
            end else if (r < 94) begin
                // Bad second sync byte, possibly another first sync.
                queue_byte({SYNC1_NIBBLE, 4'($urandom)});
                if ($urandom_range(0, 1)) queue_byte({SYNC1_NIBBLE, 4'($urandom)});
                else queue_byte(8'($urandom_range(0, 255)) & 8'hCF);
            end else begin
                // Truncated packet: the rest gets parsed as cabin bytes.
                queue_packet(1'b1, -1, $urandom_range(0, PAYLOAD_LEN - 1));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed: byte extremes while hunting, second sync rejects, then packets
        // with all-zero, all-one and random payloads, good and bad checksums.
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte({SYNC2_NIBBLE, 4'hC});          // second sync while hunting: drop
        queue_byte({SYNC1_NIBBLE, 4'h3});
        queue_byte({SYNC1_NIBBLE, 4'h7});          // rejected even though it is a first sync
        queue_byte({SYNC2_NIBBLE, 4'h1});          // hunting again: drop
        queue_byte({SYNC1_NIBBLE, 4'h1});
        queue_byte(8'h12);                         // bad second sync
        queue_packet(1'b1, 8'h00, PAYLOAD_LEN);
        queue_packet(1'b0, 8'hFF, PAYLOAD_LEN);
        queue_packet(1'b1, 8'hFF, PAYLOAD_LEN);
        queue_packet(1'b0, -1, PAYLOAD_LEN);
        wait_drained();

        // Random traffic in two phases; the sender idles between them until all is in.
        queue_random_phase();
        wait_drained();
        queue_random_phase();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Fed %0d bytes in %0d packet starts; checked %0d cabins.",
                 bytes_queued, packets_queued, cabins_checked);
        $display("Packet ends seen: %0d with matching checksum, %0d without; %0d mismatches.",
                 sums_good_seen, sums_bad_seen, errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/lcpp_pkg.sv
hdl/lidar_cabin_packet_parser.sv
tb/sv/tb_top.sv
